FILE: hw/rtl/assert_macros.svh
// assertion helpers for the checker in ptu_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ptu_pkg.sv
package ptu_pkg;

	// input word layout
	localparam int IN_W   = 240;
	localparam int OUT_W  = 88;
	localparam int LIFE_W = 10;
	localparam int MOT_W  = 48;
	localparam int SCL_W  = 16;
	localparam int COL_W  = 24;

	// kind of input word, carried on tuser
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic [LIFE_W-1:0] frame;
		logic [LIFE_W-1:0] life;
		logic [MOT_W-1:0]  position;
		logic [MOT_W-1:0]  velocity;
		logic [MOT_W-1:0]  accel;
		logic [31:0]       scale_ends;
		logic [47:0]       color_ends;
	} slot_t;

	typedef enum logic [1:0] {
		WR_ADD,
		WR_COPY,
		WR_UPD
	} wr_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_UPD_RD,
		ST_UPD_MUL,
		ST_UPD_DIV,
		ST_UPD_OUT
	} state_t;

	typedef struct packed {
		logic    rd_en;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    div_start;
		logic    out_load;
		logic    last;
	} cmd_t;

	typedef struct packed {
		logic alive;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/ptu_div_lane.sv
module ptu_div_lane (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] start_val,
	input  logic [15:0] end_val,
	input  logic [9:0]  frame,
	input  logic [9:0]  life,
	output logic        busy,
	output logic [15:0] result
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [9:0]  rem_q;
	logic [15:0] low_q;
	logic [15:0] quo_q;
	logic [15:0] start_q;
	logic        neg_q;
	logic [9:0]  den_q;

	logic        neg;
	logic [15:0] diff;
	logic [9:0]  den;
	logic [25:0] num;
	logic [10:0] trial;
	logic        ge;

	// numerator set up; a falling lerp uses the ceiling of the quotient
	always_comb begin
		neg  = end_val < start_val;
		diff = neg ? (start_val - end_val) : (end_val - start_val);
		den  = (life == 10'd0) ? 10'd1 : life;
		num  = 26'(diff) * 26'(frame) + (neg ? 26'(den - 10'd1) : 26'd0);
	end

	// one quotient bit per step
	always_comb begin
		trial = {rem_q, low_q[15]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 5'd1;
			busy_q <= cnt_q != 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= num[25:16];
			low_q   <= num[15:0];
			quo_q   <= 16'd0;
			start_q <= start_val;
			neg_q   <= neg;
			den_q   <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 10'(trial - {1'b0, den_q}) : trial[9:0];
			low_q <= {low_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign busy   = busy_q;
	assign result = neg_q ? (start_q - quo_q) : (start_q + quo_q);
endmodule

FILE: hw/rtl/ptu_datapath.sv
module ptu_datapath #(
	parameter int PARTICLE_SLOTS = 64,
	parameter int AW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptu_pkg::cmd_t        cmd,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	input  logic [ptu_pkg::IN_W-1:0] in_word,
	input  logic                 m_tready,
	output ptu_pkg::status_t     st,
	output logic                 m_tvalid,
	output logic [ptu_pkg::OUT_W-1:0] m_tdata,
	output logic                 m_tlast
);
	import ptu_pkg::*;

	slot_t mem [PARTICLE_SLOTS];
	slot_t rd_q;
	slot_t upd_q;
	slot_t upd_d;
	slot_t add_word;
	slot_t wr_word;

	logic [LIFE_W-1:0] fr;
	logic [MOT_W-1:0]  vel_n;
	logic [MOT_W-1:0]  pos_n;
	logic [3:0]        busy_l;
	logic [15:0]       res_l [4];
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_last_q;

	function automatic logic [MOT_W-1:0] add_sat3(logic [MOT_W-1:0] a, logic [MOT_W-1:0] b);
		logic [MOT_W-1:0] r;
		logic [16:0] s;
		for (int k = 0; k < 3; k++) begin
			s = {a[16*k+15], a[16*k +: 16]} + {b[16*k+15], b[16*k +: 16]};
			if (s[16] != s[15])
				r[16*k +: 16] = s[16] ? 16'h8000 : 16'h7fff;
			else
				r[16*k +: 16] = s[15:0];
		end
		return r;
	endfunction

	// new particle from the input word
	always_comb begin
		add_word.frame      = '0;
		add_word.life       = in_word[9:0];
		add_word.position   = in_word[57:10];
		add_word.velocity   = in_word[105:58];
		add_word.accel      = in_word[153:106];
		add_word.scale_ends = in_word[185:154];
		add_word.color_ends = in_word[233:186];
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_ADD:  wr_word = add_word;
			WR_COPY: wr_word = rd_q;
			WR_UPD:  wr_word = upd_q;
			default: wr_word = rd_q;
		endcase
	end

	// slot table
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wr_addr] <= wr_word;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	// euler step on the slot just read
	always_comb begin
		fr    = rd_q.frame + 10'd1;
		vel_n = add_sat3(rd_q.velocity, rd_q.accel);
		pos_n = add_sat3(rd_q.position, vel_n);
		upd_d          = rd_q;
		upd_d.frame    = fr;
		upd_d.velocity = vel_n;
		upd_d.position = pos_n;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			upd_q <= upd_d;
	end

	// interpolation lanes: scale, then r, g, b
	ptu_div_lane u_lane_scale (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.start_val(rd_q.scale_ends[15:0]), .end_val(rd_q.scale_ends[31:16]),
		.frame(fr), .life(rd_q.life), .busy(busy_l[0]), .result(res_l[0])
	);

	for (genvar c = 0; c < 3; c++) begin : g_col
		ptu_div_lane u_lane_col (
			.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
			.start_val({8'd0, rd_q.color_ends[8*c +: 8]}),
			.end_val({8'd0, rd_q.color_ends[24+8*c +: 8]}),
			.frame(fr), .life(rd_q.life), .busy(busy_l[c+1]), .result(res_l[c+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {res_l[3][7:0], res_l[2][7:0], res_l[1][7:0], res_l[0], upd_q.position};
			out_last_q <= cmd.last;
		end
	end

	assign st.alive    = rd_q.frame < rd_q.life;
	assign st.div_busy = |busy_l;
	assign st.out_free = !out_valid_q || m_tready;
	assign m_tvalid    = out_valid_q;
	assign m_tdata     = out_data_q;
	assign m_tlast     = out_last_q;
endmodule

FILE: hw/rtl/ptu_ctrl.sv
module ptu_ctrl #(
	parameter int PARTICLE_SLOTS = 64,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	input  ptu_pkg::status_t st,
	output logic             s_tready,
	output ptu_pkg::cmd_t    cmd,
	output logic [AW-1:0]    rd_addr,
	output logic [AW-1:0]    wr_addr
);
	import ptu_pkg::*;

	state_t state_q, state_d;
	logic [CW-1:0] live_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] keep_q;
	logic          in_acc;
	logic          full;

	assign in_acc = s_tvalid && s_tready;
	assign full   = live_q >= CW'(PARTICLE_SLOTS);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_acc && s_tuser == ACT_TICK) state_d = ST_CMP_RD;
			ST_CMP_RD: begin
				if (idx_q == live_q)
					state_d = (keep_q == '0) ? ST_IDLE : ST_UPD_RD;
				else
					state_d = ST_CMP_CHK;
			end
			ST_CMP_CHK: state_d = ST_CMP_RD;
			ST_UPD_RD:  state_d = ST_UPD_MUL;
			ST_UPD_MUL: state_d = ST_UPD_DIV;
			ST_UPD_DIV: if (!st.div_busy) state_d = ST_UPD_OUT;
			ST_UPD_OUT: begin
				if (st.out_free)
					state_d = (idx_q == '0) ? ST_IDLE : ST_UPD_RD;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		cmd.wr_sel = WR_ADD;
		s_tready  = 1'b0;
		rd_addr   = idx_q[AW-1:0];
		wr_addr   = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.wr_en  = in_acc && s_tuser == ACT_ADD && !full;
				wr_addr    = live_q[AW-1:0];
			end
			ST_CMP_RD:  cmd.rd_en = idx_q != live_q;
			ST_CMP_CHK: begin
				cmd.wr_en  = st.alive;
				cmd.wr_sel = WR_COPY;
				wr_addr    = keep_q[AW-1:0];
			end
			ST_UPD_RD:  cmd.rd_en = 1'b1;
			ST_UPD_MUL: cmd.div_start = 1'b1;
			ST_UPD_OUT: begin
				cmd.wr_en    = st.out_free;
				cmd.wr_sel   = WR_UPD;
				cmd.out_load = st.out_free;
				cmd.last     = idx_q == '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			live_q  <= '0;
			idx_q   <= '0;
			keep_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == ACT_ADD && !full)
						live_q <= live_q + CW'(1);
					idx_q  <= '0;
					keep_q <= '0;
				end
				ST_CMP_RD: begin
					// compaction done: walk survivors newest first
					if (idx_q == live_q) begin
						live_q <= keep_q;
						idx_q  <= keep_q - CW'(1);
					end
				end
				ST_CMP_CHK: begin
					if (st.alive)
						keep_q <= keep_q + CW'(1);
					idx_q <= idx_q + CW'(1);
				end
				ST_UPD_OUT: begin
					if (st.out_free && idx_q != '0)
						idx_q <= idx_q - CW'(1);
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: hw/rtl/particle_table_update.sv
// particle table with per-frame euler update
// input stream: s_tvalid/s_tready/s_tdata/s_tuser; tuser is the action
// (0 add a particle, 1 frame tick); tdata carries the particle on an add
// output stream: one word per surviving particle on a tick, newest first,
// m_tlast set on the oldest one; no words for an add or an empty tick
// an add is written in the cycle it is taken; a full table drops it silently
// a tick first walks every live slot to drop expired ones, a read and a
// check per slot, then updates each survivor: read, euler step and
// multiply, a bit-serial division for the interpolation, and a write
// back that also loads the output register
// the division lanes set the per-particle time
// input is taken only between items; a word waiting at the output does not
// stop an add from being taken, and a stalled receiver holds the tick at
// its next output word
// reset empties the table at once; slot contents are not cleared
module particle_table_update #(
	parameter int PARTICLE_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// life_frames, start_position, start_velocity, acceleration,
	// scale_begin, scale_finish, color_begin, color_finish, zero pad
	input  logic [239:0] s_tdata,
	// action
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_position, out_scale, out_color
	output logic [87:0]  m_tdata,
	// last_particle
	output logic         m_tlast
);
	import ptu_pkg::*;

	localparam int AW = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;
	localparam int CW = $clog2(PARTICLE_SLOTS + 1) + 1;

	cmd_t          cmd;
	status_t       st;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	ptu_ctrl #(.PARTICLE_SLOTS(PARTICLE_SLOTS), .AW(AW), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tuser(s_tuser),
		.st(st), .s_tready(s_tready), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr)
	);

	ptu_datapath #(.PARTICLE_SLOTS(PARTICLE_SLOTS), .AW(AW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
		.in_word(s_tdata), .m_tready(m_tready), .st(st), .m_tvalid(m_tvalid),
		.m_tdata(m_tdata), .m_tlast(m_tlast)
	);
endmodule

FILE: hw/rtl/ptu_checker.sv
`include "assert_macros.svh"

module ptu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [239:0] s_tdata,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [87:0]  m_tdata,
	input logic         m_tlast
);
	// a stalled word stays offered
	`PTU_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output word dropped")
	// and keeps its contents
	`PTU_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast),
		"stalled output changed")
	// a tick occupies the block
	`PTU_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && s_tuser == ptu_pkg::ACT_TICK, !s_tready,
		"input taken during a tick")
endmodule

bind particle_table_update ptu_checker u_ptu_checker (.*);

FILE: sim/particle_checker.sv
`timescale 1ns / 1ps

// watches both streams, predicts the particle table and compares every output word
module particle_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [239:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [87:0]  m_tdata,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending,
	output int           ticks_seen,
	output int           words_seen
);
	import ptu_pkg::*;

	localparam int SLOTS = 64;

	typedef struct packed {
		logic [47:0] position;
		logic [15:0] scale;
		logic [23:0] color;
		logic        last;
	} particle_word_t;

	// model of the table, oldest particle in slot 0
	int unsigned      live;
	logic [9:0]       frame_q [SLOTS];
	logic [9:0]       life_q [SLOTS];
	logic [47:0]      pos_q [SLOTS];
	logic [47:0]      vel_q [SLOTS];
	logic [47:0]      acc_q [SLOTS];
	logic [31:0]      scale_q [SLOTS];
	logic [47:0]      color_q [SLOTS];
	particle_word_t   due_words [$];

	// per-lane signed q8.8 add with saturation
	function automatic logic [47:0] sat_add3(logic [47:0] a, logic [47:0] b);
		logic [47:0] r;
		logic signed [16:0] s;
		for (int k = 0; k < 3; k++) begin
			s = $signed({a[16*k+15], a[16*k +: 16]}) + $signed({b[16*k+15], b[16*k +: 16]});
			if (s > 17'sd32767)
				s = 17'sd32767;
			else if (s < -17'sd32768)
				s = -17'sd32768;
			r[16*k +: 16] = s[15:0];
		end
		return r;
	endfunction

	// start + (finish - start) * fr / lf, rounded down
	function automatic longint unsigned interp(longint unsigned st, longint unsigned fin,
			longint unsigned fr, longint unsigned lf);
		if (fin >= st)
			return st + ((fin - st) * fr) / lf;
		return st - (((st - fin) * fr + lf - 1) / lf);
	endfunction

	task automatic predict_add(logic [239:0] d);
		if (live >= SLOTS)
			return;
		frame_q[live] = '0;
		life_q[live]  = d[9:0];
		pos_q[live]   = d[57:10];
		vel_q[live]   = d[105:58];
		acc_q[live]   = d[153:106];
		scale_q[live] = d[185:154];
		color_q[live] = d[233:186];
		live++;
	endtask

	task automatic predict_tick();
		int unsigned keep;
		int unsigned fr;
		int unsigned lf;
		particle_word_t w;
		keep = 0;
		// drop expired particles, order kept
		for (int i = 0; i < live; i++) begin
			if (frame_q[i] < life_q[i]) begin
				frame_q[keep] = frame_q[i];
				life_q[keep]  = life_q[i];
				pos_q[keep]   = pos_q[i];
				vel_q[keep]   = vel_q[i];
				acc_q[keep]   = acc_q[i];
				scale_q[keep] = scale_q[i];
				color_q[keep] = color_q[i];
				keep++;
			end
		end
		live = keep;
		// update survivors, newest first
		for (int s = int'(keep) - 1; s >= 0; s--) begin
			frame_q[s] = frame_q[s] + 10'd1;
			fr = frame_q[s];
			lf = (life_q[s] == 0) ? 1 : life_q[s];
			vel_q[s] = sat_add3(vel_q[s], acc_q[s]);
			pos_q[s] = sat_add3(pos_q[s], vel_q[s]);
			w.position = pos_q[s];
			w.scale = 16'(interp(scale_q[s][15:0], scale_q[s][31:16], fr, lf));
			for (int c = 0; c < 3; c++)
				w.color[8*c +: 8] = 8'(interp(color_q[s][8*c +: 8],
					color_q[s][24+8*c +: 8], fr, lf));
			w.last = (s == 0);
			due_words.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		particle_word_t got;
		particle_word_t want;
		if (!arst_n) begin
			live = 0;
			due_words.delete();
			fail_count <= 0;
			ticks_seen <= 0;
			words_seen <= 0;
			pending    <= 0;
		end else begin
			// input word accepted
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_TICK) begin
					predict_tick();
					ticks_seen <= ticks_seen + 1;
				end else begin
					predict_add(s_tdata);
				end
			end
			// output word accepted
			if (m_tvalid && m_tready) begin
				got = {m_tdata[47:0], m_tdata[63:48], m_tdata[87:64], m_tlast};
				words_seen <= words_seen + 1;
				if (due_words.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output word %h last %b", m_tdata, m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					want = due_words.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch pos %h/%h scale %h/%h colour %h/%h last %b/%b (exp/got)",
								want.position, got.position, want.scale, got.scale,
								want.color, got.color, want.last, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= due_words.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import ptu_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [239:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [87:0]  m_tdata;
	logic         m_tlast;
	int           fail_count;
	int           pending;
	int           ticks_seen;
	int           words_seen;
	int           cycles = 0;
	bit           stall_enable;

	particle_table_update dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	particle_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending),
		.ticks_seen(ticks_seen), .words_seen(words_seen)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 15);
		return ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
	endfunction

	// receiver back-pressure
	int ready_hold = 0;
	always @(posedge clk) begin
		if (!stall_enable) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(3) == 0) begin
			ready_hold <= gap_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [239:0] pack_particle(logic [9:0] life, logic [47:0] pos,
			logic [47:0] vel, logic [47:0] acc, logic [15:0] sb, logic [15:0] sf,
			logic [23:0] cb, logic [23:0] cf);
		return {6'd0, cf, cb, sf, sb, acc, vel, pos, life};
	endfunction

	// hand one word over, leaving tvalid up for a back-to-back successor unless a gap is drawn
	task automatic send_word(logic act, logic [239:0] d);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gap = stall_enable ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_add(logic [9:0] life);
		send_word(ACT_ADD, pack_particle(life, rand48(), rand48(), rand48(),
			16'($urandom()), 16'($urandom()), 24'($urandom()), 24'($urandom())));
	endtask

	task automatic send_tick();
		send_word(ACT_TICK, 240'({$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()}));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int adds;
		stall_enable = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = ACT_ADD;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, saturation both ways, zero and one frame life,
		// falling interpolation, all-ones word
		send_tick();
		send_word(ACT_ADD, pack_particle(10'd1023, {3{16'h7f00}}, {3{16'h7fff}},
			{3{16'h7fff}}, 16'h0000, 16'hffff, 24'h000000, 24'hffffff));
		send_word(ACT_ADD, pack_particle(10'd3, {3{16'h8100}}, {3{16'h8000}},
			{3{16'h8000}}, 16'hffff, 16'h0000, 24'hffffff, 24'h000000));
		send_word(ACT_ADD, pack_particle(10'd0, rand48(), rand48(), rand48(),
			16'h1234, 16'h4321, 24'h102030, 24'h302010));
		send_word(ACT_ADD, pack_particle(10'd1, '0, '0, '0, 16'h0100, 16'h0300,
			24'h00ff00, 24'hff00ff));
		send_word(ACT_ADD, {240{1'b1}});
		send_word(ACT_ADD, '0);
		repeat (5) send_tick();
		drain();

		// random traffic with stalls on both sides
		stall_enable = 1'b1;
		for (int n = 0; n < 20; n++) begin
			if (n == 10)
				drain();
			if ($urandom_range(99) < 35)
				send_tick();
			else
				send_random_add(10'(($urandom_range(9) < 8) ? $urandom_range(12) :
					$urandom_range(1023)));
		end

		// fill the table past capacity, then tick it, with and without stalls
		adds = 0;
		while (adds < 66) begin
			send_random_add(10'($urandom_range(1023, 3)));
			adds++;
		end
		send_tick();
		drain();
		stall_enable = 1'b0;
		send_tick();
		send_tick();

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d ticks and %0d particle words, incl. full table and saturation",
			ticks_seen, words_seen);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
